[src/dlfs_pkg.sv]
// Shared types, codes and helper functions for the diagnostic link frame sequencer.
package dlfs_pkg;

  // Kind of an incoming item.
  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_TICK    = 2'd1,
    OP_MODE    = 2'd2,
    OP_RESTART = 2'd3
  } op_t;

  // Receive status codes.
  localparam logic [2:0] ST_SEARCH   = 3'd0;
  localparam logic [2:0] ST_HDR      = 3'd1;
  localparam logic [2:0] ST_STORED   = 3'd2;
  localparam logic [2:0] ST_GOOD     = 3'd3;
  localparam logic [2:0] ST_CSUM_ERR = 3'd4;
  localparam logic [2:0] ST_REJECT   = 3'd5;

  // Command codes.
  localparam logic [3:0] CMD_NONE     = 4'd0;
  localparam logic [3:0] CMD_MODE0    = 4'd1;
  localparam logic [3:0] CMD_MODE1    = 4'd2;
  localparam logic [3:0] CMD_SHUTUP   = 4'd3;
  localparam logic [3:0] CMD_GET      = 4'd4;
  localparam logic [3:0] CMD_CLR      = 4'd5;
  localparam logic [3:0] CMD_CLR_BLM  = 4'd6;
  localparam logic [3:0] CMD_RST_IAC  = 4'd7;
  localparam logic [3:0] CMD_SET_IDLE = 4'd8;

  // Header and length constants.
  localparam logic [7:0] HDR_MAIN = 8'hF4;
  localparam logic [7:0] HDR_ALT1 = 8'h05;
  localparam logic [7:0] HDR_ALT2 = 8'h0A;
  localparam logic [7:0] LEN_BIAS = 8'h55;

  localparam int NUM_EV = 9;

  // Event bit positions.
  localparam int EV_IDLE   = 0;
  localparam int EV_SHUTUP = 1;
  localparam int EV_D0     = 2;
  localparam int EV_M1REQ  = 3;
  localparam int EV_D1     = 4;
  localparam int EV_M3REQ  = 5;
  localparam int EV_D3     = 6;
  localparam int EV_M4REQ  = 7;
  localparam int EV_D4     = 8;

  // Mode codes as reported on current_mode.
  localparam logic [2:0] MODE_0 = 3'd0;
  localparam logic [2:0] MODE_1 = 3'd1;
  localparam logic [2:0] MODE_3 = 3'd3;
  localparam logic [2:0] MODE_4 = 3'd4;

  // Information about the byte just taken by the framer.
  typedef struct packed {
    logic       done;
    logic [2:0] status;
    logic [7:0] hdr;
    logic [7:0] len;
    logic [7:0] third;
    logic [7:0] last;
  } frame_info_t;

  // Command that answers a requested mode; the unsupported mode maps to none.
  function automatic logic [3:0] mode_cmd(input logic [2:0] mode);
    logic [3:0] c;
    case (mode)
      3'd0:    c = CMD_MODE0;
      3'd1:    c = CMD_MODE1;
      3'd3:    c = CMD_GET;
      3'd4:    c = CMD_CLR;
      3'd5:    c = CMD_CLR_BLM;
      3'd6:    c = CMD_RST_IAC;
      3'd7:    c = CMD_SET_IDLE;
      default: c = CMD_NONE;
    endcase
    return c;
  endfunction

endpackage

[src/dlfs_framer.sv]
// Byte framer: header, length, data and checksum phases of the receive side.
module dlfs_framer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  dlfs_pkg::op_t        op,
  input  logic [7:0]           rx_byte,
  output dlfs_pkg::frame_info_t info
);
  import dlfs_pkg::*;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_LENGTH = 4'b0010,
    PH_DATA   = 4'b0100,
    PH_CHECK  = 4'b1000
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic       first_r, first_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] hdr_r, hdr_nxt;
  logic [7:0] third_r, third_nxt;
  logic       hdr_ok;
  logic [7:0] cnt_inc;

  assign hdr_ok  = (rx_byte == HDR_MAIN) ||
                   (!first_r && ((rx_byte == HDR_ALT1) || (rx_byte == HDR_ALT2)));
  assign cnt_inc = cnt_r + 8'd1;

  always_comb begin
    phase_nxt   = phase_r;
    first_nxt   = first_r;
    len_nxt     = len_r;
    cnt_nxt     = cnt_r;
    sum_nxt     = sum_r;
    hdr_nxt     = hdr_r;
    third_nxt   = third_r;
    info        = '0;
    info.hdr    = hdr_r;
    info.len    = len_r;
    info.third  = third_r;
    info.last   = rx_byte;
    if (op == OP_RESTART) begin
      phase_nxt = PH_HEADER;
      first_nxt = 1'b1;
      len_nxt   = '0;
      cnt_nxt   = '0;
      sum_nxt   = '0;
      hdr_nxt   = '0;
      third_nxt = '0;
    end else if (op == OP_BYTE) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (hdr_ok) begin
            first_nxt   = 1'b0;
            hdr_nxt     = rx_byte;
            sum_nxt     = rx_byte;
            phase_nxt   = PH_LENGTH;
            info.status = ST_HDR;
          end else begin
            info.status = first_r ? ST_SEARCH : ST_REJECT;
          end
        end
        PH_LENGTH: begin
          len_nxt     = rx_byte - LEN_BIAS;
          sum_nxt     = sum_r + rx_byte;
          cnt_nxt     = '0;
          phase_nxt   = (len_nxt == 8'd0) ? PH_CHECK : PH_DATA;
          info.status = ST_STORED;
        end
        PH_DATA: begin
          if (cnt_r == 8'd0) begin
            third_nxt = rx_byte;
          end
          sum_nxt = sum_r + rx_byte;
          cnt_nxt = cnt_inc;
          if (cnt_inc >= len_r) begin
            phase_nxt = PH_CHECK;
          end
          info.status = ST_STORED;
        end
        PH_CHECK: begin
          // With no data bytes the checksum byte doubles as the third byte.
          if (len_r == 8'd0) begin
            third_nxt = rx_byte;
          end
          info.third = third_nxt;
          sum_nxt    = sum_r + rx_byte;
          info.done  = 1'b1;
          if (sum_nxt == 8'd0) begin
            info.status = ST_GOOD;
          end else begin
            info.status = ST_CSUM_ERR;
            first_nxt   = 1'b1;
          end
          phase_nxt = PH_HEADER;
          len_nxt   = '0;
          cnt_nxt   = '0;
        end
        default: begin
          phase_nxt = PH_HEADER;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      first_r <= 1'b1;
      len_r   <= '0;
      cnt_r   <= '0;
      sum_r   <= '0;
      hdr_r   <= '0;
      third_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      first_r <= first_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      hdr_r   <= hdr_nxt;
      third_r <= third_nxt;
    end
  end

endmodule

[src/dlfs_seq.sv]
// Frame sorter and request sequencer that picks the next command to send.
module dlfs_seq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  dlfs_pkg::op_t         op,
  input  logic [2:0]            req_mode,
  input  logic [7:0]            req_data,
  input  logic                  interactive,
  input  dlfs_pkg::frame_info_t info,
  output logic [8:0]            events,
  output logic [3:0]            send_cmd,
  output logic [7:0]            idle_value,
  output logic [2:0]            current_mode
);
  import dlfs_pkg::*;

  logic [1:0] su_r, su_nxt;
  logic [2:0] wanted_r, wanted_nxt;
  logic       pend_r, pend_nxt;
  logic [7:0] idle_r, idle_nxt;
  logic [2:0] mode_r, mode_nxt;
  logic       tout_r, tout_nxt;

  logic [NUM_EV-1:0] ev;
  logic [8:0]        total;
  logic [3:0]        nc;
  logic [3:0]        cmd;
  logic              sent;
  logic              take;
  logic              frame;

  assign total = {1'b0, info.len} + 9'd3;
  assign frame = (op == OP_BYTE) && info.done;

  always_comb begin
    ev            = '0;
    ev[EV_IDLE]   = (info.hdr == HDR_MAIN) && (total == 9'd3) && (info.last == 8'hB7);
    ev[EV_SHUTUP] = (info.hdr == HDR_MAIN) && (total == 9'd4) && (info.last == 8'hAE);
    ev[EV_D0]     = (total == 9'd6);
    ev[EV_M1REQ]  = (total == 9'd5) && (info.third == 8'h01) && (info.last == 8'hB5);
    ev[EV_D1]     = (total == 9'd67) && (info.third == 8'h01);
    ev[EV_M3REQ]  = (total == 9'd10) && (info.third == 8'h03);
    ev[EV_D3]     = (total == 9'd7) && (info.third == 8'h03);
    ev[EV_M4REQ]  = (total == 9'd14) && (info.third == 8'h04);
    ev[EV_D4]     = (total == 9'd4) && (info.third == 8'h04);
  end

  // Command that a handler would send right now.
  assign nc = pend_r ? mode_cmd(wanted_r) : CMD_MODE1;

  always_comb begin
    su_nxt     = su_r;
    wanted_nxt = wanted_r;
    pend_nxt   = pend_r;
    idle_nxt   = idle_r;
    mode_nxt   = mode_r;
    tout_nxt   = tout_r;
    cmd        = CMD_NONE;
    sent       = 1'b0;
    take       = 1'b0;
    if (frame) begin
      // Handlers run in a fixed order; only the first one that may send does.
      if (ev[EV_IDLE] && interactive) begin
        cmd  = CMD_SHUTUP;
        sent = 1'b1;
      end
      if (ev[EV_SHUTUP] && interactive && !sent) begin
        if (su_r >= 2'd2) begin
          cmd    = nc;
          sent   = 1'b1;
          take   = 1'b1;
          su_nxt = 2'd1;
        end else begin
          su_nxt = su_r + 2'd1;
        end
      end
      if (ev[EV_D0]) begin
        mode_nxt = MODE_0;
      end
      if (ev[EV_D1]) begin
        mode_nxt = MODE_1;
        if (interactive && !sent) begin
          cmd  = nc;
          sent = 1'b1;
          take = 1'b1;
        end
      end
      if (ev[EV_D3]) begin
        mode_nxt = MODE_3;
        if (interactive && !sent) begin
          cmd  = nc;
          sent = 1'b1;
          take = 1'b1;
        end
      end
      if (ev[EV_D4]) begin
        mode_nxt = MODE_4;
        if (interactive && !sent) begin
          cmd  = nc;
          sent = 1'b1;
          take = 1'b1;
        end
      end
      if (take) begin
        tout_nxt = 1'b0;
        pend_nxt = 1'b0;
      end
    end else if (op == OP_TICK) begin
      if (interactive) begin
        mode_nxt = MODE_1;
        if (tout_r) begin
          cmd      = nc;
          pend_nxt = 1'b0;
        end
        tout_nxt = 1'b1;
      end
    end else if (op == OP_MODE) begin
      idle_nxt   = req_data;
      wanted_nxt = req_mode;
      pend_nxt   = 1'b1;
    end else if (op == OP_RESTART) begin
      // Restart keeps the timeout flag.
      mode_nxt   = MODE_0;
      wanted_nxt = 3'd1;
      pend_nxt   = 1'b0;
      idle_nxt   = '0;
      su_nxt     = 2'd1;
      cmd        = CMD_MODE0;
    end
  end

  assign events       = frame ? ev : '0;
  assign send_cmd     = cmd;
  assign idle_value   = (cmd == CMD_SET_IDLE) ? idle_nxt : 8'd0;
  assign current_mode = mode_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      su_r     <= 2'd1;
      wanted_r <= 3'd1;
      pend_r   <= 1'b0;
      idle_r   <= '0;
      mode_r   <= MODE_0;
      tout_r   <= 1'b0;
    end else if (step) begin
      su_r     <= su_nxt;
      wanted_r <= wanted_nxt;
      pend_r   <= pend_nxt;
      idle_r   <= idle_nxt;
      mode_r   <= mode_nxt;
      tout_r   <= tout_nxt;
    end
  end

endmodule

[src/diag_link_frame_sequencer.sv]
// An accepted item waits in the input register and its result in the result register, which drives
// out_tvalid. Throughput: one item per cycle unless out_tready holds the result register full;
// all per-item work is one pass of logic between the registers.
// The input register refills in the same cycle its item moves to a free or draining result register.
// Reset (rst_n low, synchronous): framer returns to header search, sequencer to its start values,
// the interactive register clears and both registers drop their valid flags.
module diag_link_frame_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] rx_byte, [10:8] req_mode, [18:11] req_data, rest zero
  input  logic [1:0]  in_tuser,   // [1:0] op
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [2:0] rx_status, [11:3] events, [15:12] send_cmd,
                                  // [23:16] idle_value, [26:24] current_mode, rest zero
  output logic        out_tlast,  // frame_done: this byte completed a frame
  // Configuration write channel for the interactive register.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);
  import dlfs_pkg::*;

  // Input register. It holds one item until the logic can pass its result on.
  logic       in_v_r;
  op_t        op_r;
  logic [7:0] byte_r;
  logic [2:0] mode_r;
  logic [7:0] data_r;

  // Result register.
  logic        out_v_r;
  logic [2:0]  status_r;
  logic        done_r;
  logic [8:0]  events_r;
  logic [3:0]  cmd_r;
  logic [7:0]  idle_r;
  logic [2:0]  cur_r;

  logic        interactive_r;

  logic        adv;
  frame_info_t info;
  logic [8:0]  events;
  logic [3:0]  send_cmd;
  logic [7:0]  idle_value;
  logic [2:0]  current_mode;

  // The item in the input register is processed in the cycle it moves on, so the
  // framer and sequencer state update exactly once per item, in order.
  assign adv       = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      op_r   <= op_t'(in_tuser);
      byte_r <= in_tdata[7:0];
      mode_r <= in_tdata[10:8];
      data_r <= in_tdata[18:11];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interactive_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      interactive_r <= cfg_data;
    end
  end

  dlfs_framer u_framer (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (adv),
    .op      (op_r),
    .rx_byte (byte_r),
    .info    (info)
  );

  dlfs_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (adv),
    .op           (op_r),
    .req_mode     (mode_r),
    .req_data     (data_r),
    .interactive  (interactive_r),
    .info         (info),
    .events       (events),
    .send_cmd     (send_cmd),
    .idle_value   (idle_value),
    .current_mode (current_mode)
  );

  // A result waits here until its transfer completes; a new one can load in the same cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status_r <= info.status;
      done_r   <= info.done;
      events_r <= events;
      cmd_r    <= send_cmd;
      idle_r   <= idle_value;
      cur_r    <= current_mode;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tlast  = done_r;
  assign out_tdata  = {5'd0, cur_r, idle_r, cmd_r, events_r, status_r};

endmodule

[bench/diag_link_frame_sequencer_tb.sv]
// Self-checking testbench for the diagnostic link frame sequencer with a built-in predictor.
`timescale 1ns / 1ps

module diag_link_frame_sequencer_tb;
  import dlfs_pkg::*;

  // Framer phases of the predictor.
  typedef enum logic [1:0] {
    FR_HEADER,
    FR_LENGTH,
    FR_DATA,
    FR_CHECK
  } framer_phase_t;

  // Mode numbers as they arrive with a mode request.
  typedef enum logic [2:0] {
    RQ_MODE0,
    RQ_MODE1,
    RQ_UNSUP,
    RQ_GET,
    RQ_CLR,
    RQ_CLR_BLM,
    RQ_RST_IAC,
    RQ_SET_IDLE
  } req_mode_t;

  // Frame shapes the random stimulus builds; FK_ANY has a random length.
  typedef enum int {
    FK_IDLE,
    FK_SHUTUP,
    FK_D0,
    FK_M1REQ,
    FK_D1,
    FK_M3REQ,
    FK_D3,
    FK_M4REQ,
    FK_D4,
    FK_ANY
  } frame_kind_t;

  // Fields of one result transfer.
  typedef struct packed {
    logic [2:0] status;
    logic       done;
    logic [8:0] events;
    logic [3:0] cmd;
    logic [7:0] idle;
    logic [2:0] mode;
  } link_result_t;

  // Trailing bytes, third bytes and total lengths that classify a frame.
  localparam logic [7:0] END_IDLE   = 8'hB7;
  localparam logic [7:0] END_SHUTUP = 8'hAE;
  localparam logic [7:0] END_M1REQ  = 8'hB5;
  localparam logic [7:0] TAG_MODE1  = 8'h01;
  localparam logic [7:0] TAG_MODE3  = 8'h03;
  localparam logic [7:0] TAG_MODE4  = 8'h04;
  localparam int TOT_IDLE   = 3;
  localparam int TOT_SHORT  = 4;
  localparam int TOT_M1REQ  = 5;
  localparam int TOT_D0     = 6;
  localparam int TOT_D3     = 7;
  localparam int TOT_M3REQ  = 10;
  localparam int TOT_M4REQ  = 14;
  localparam int TOT_D1     = 67;
  localparam int HOLD_CYCLES = 60;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // [7:0] rx_byte, [10:8] req_mode, [18:11] req_data, rest zero
  logic [1:0]  in_tuser;   // [1:0] op
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [2:0] rx_status, [11:3] events, [15:12] send_cmd,
                           // [23:16] idle_value, [26:24] current_mode, rest zero
  logic        out_tlast;  // frame_done
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;

  // Predictor state: a shadow of the framer, the request sequencer and the register.
  framer_phase_t fr_phase;
  logic       hunt_first;
  logic [7:0] frame_len;
  logic [7:0] data_seen;
  logic [7:0] byte_sum;
  logic [7:0] hdr_byte;
  logic [7:0] third_byte;
  logic [1:0] shutup_cnt;
  logic [2:0] wanted_mode;
  logic       mode_pending;
  logic [7:0] idle_byte;
  logic [2:0] mode_now;
  logic       timed_out;
  logic       interactive;

  // Results the block owes, oldest first.
  link_result_t expected_link_results[$];
  logic [7:0]   frame_buf[$];

  int mismatches = 0;
  int items_sent = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_seq = 0;

  diag_link_frame_sequencer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard limit on the whole run, far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // Framer and sequencer back to their start values; a restart keeps the timeout flag
  // and the register, so those two are not touched here.
  function automatic void clear_link_state();
    fr_phase     = FR_HEADER;
    hunt_first   = 1'b1;
    frame_len    = 8'h00;
    data_seen    = 8'h00;
    byte_sum     = 8'h00;
    hdr_byte     = 8'h00;
    third_byte   = 8'h00;
    shutup_cnt   = 2'd1;
    wanted_mode  = RQ_MODE1;
    mode_pending = 1'b0;
    idle_byte    = 8'h00;
    mode_now     = MODE_0;
  endfunction

  // The sequencer's choice of the next request: a pending mode request wins, otherwise
  // the block asks for mode 1. The unsupported mode yields no command at all.
  function automatic logic [3:0] issue_request();
    logic [3:0] c;
    timed_out = 1'b0;
    if (mode_pending) begin
      case (req_mode_t'(wanted_mode))
        RQ_MODE0:    c = CMD_MODE0;
        RQ_MODE1:    c = CMD_MODE1;
        RQ_GET:      c = CMD_GET;
        RQ_CLR:      c = CMD_CLR;
        RQ_CLR_BLM:  c = CMD_CLR_BLM;
        RQ_RST_IAC:  c = CMD_RST_IAC;
        RQ_SET_IDLE: c = CMD_SET_IDLE;
        default:     c = CMD_NONE;
      endcase
      mode_pending = 1'b0;
    end else begin
      c = CMD_MODE1;
    end
    return c;
  endfunction

  // Advances the shadow state by one accepted item and returns the result it causes.
  function automatic link_result_t predict_link_item(op_t op, logic [7:0] rx,
                                                     logic [2:0] rq, logic [7:0] rd);
    link_result_t r;
    logic [8:0]   ev;
    logic [3:0]   cmd;
    logic         sent;
    int           total;
    r    = '0;
    ev   = '0;
    cmd  = CMD_NONE;
    sent = 1'b0;
    case (op)
      OP_BYTE: begin
        case (fr_phase)
          FR_HEADER: begin
            // Until a first header is seen only the main header counts.
            if (rx == HDR_MAIN || (!hunt_first && (rx == HDR_ALT1 || rx == HDR_ALT2))) begin
              hunt_first = 1'b0;
              hdr_byte   = rx;
              byte_sum   = rx;
              fr_phase   = FR_LENGTH;
              r.status   = ST_HDR;
            end else begin
              r.status = hunt_first ? ST_SEARCH : ST_REJECT;
            end
          end
          FR_LENGTH: begin
            frame_len = rx - LEN_BIAS;
            byte_sum  = byte_sum + rx;
            data_seen = 8'h00;
            fr_phase  = (frame_len == 8'h00) ? FR_CHECK : FR_DATA;
            r.status  = ST_STORED;
          end
          FR_DATA: begin
            if (data_seen == 8'h00) third_byte = rx;
            byte_sum  = byte_sum + rx;
            data_seen = data_seen + 8'h01;
            if (data_seen >= frame_len) fr_phase = FR_CHECK;
            r.status = ST_STORED;
          end
          default: begin
            // Without data the checksum byte doubles as the third byte.
            if (frame_len == 8'h00) third_byte = rx;
            byte_sum = byte_sum + rx;
            total    = int'(frame_len) + 3;
            ev[EV_IDLE]   = hdr_byte == HDR_MAIN && total == TOT_IDLE && rx == END_IDLE;
            ev[EV_SHUTUP] = hdr_byte == HDR_MAIN && total == TOT_SHORT && rx == END_SHUTUP;
            ev[EV_D0]     = total == TOT_D0;
            ev[EV_M1REQ]  = total == TOT_M1REQ && third_byte == TAG_MODE1 && rx == END_M1REQ;
            ev[EV_D1]     = total == TOT_D1 && third_byte == TAG_MODE1;
            ev[EV_M3REQ]  = total == TOT_M3REQ && third_byte == TAG_MODE3;
            ev[EV_D3]     = total == TOT_D3 && third_byte == TAG_MODE3;
            ev[EV_M4REQ]  = total == TOT_M4REQ && third_byte == TAG_MODE4;
            ev[EV_D4]     = total == TOT_SHORT && third_byte == TAG_MODE4;
            // Handlers in fixed order; only the first one that sends gets to send.
            if (ev[EV_IDLE] && interactive) begin
              cmd  = CMD_SHUTUP;
              sent = 1'b1;
            end
            if (ev[EV_SHUTUP] && interactive && !sent) begin
              if (shutup_cnt >= 2'd2) begin
                cmd        = issue_request();
                sent       = 1'b1;
                shutup_cnt = 2'd0;
              end
              shutup_cnt = shutup_cnt + 2'd1;
            end
            if (ev[EV_D0]) mode_now = MODE_0;
            if (ev[EV_D1]) begin
              mode_now = MODE_1;
              if (interactive && !sent) begin
                cmd  = issue_request();
                sent = 1'b1;
              end
            end
            if (ev[EV_D3]) begin
              mode_now = MODE_3;
              if (interactive && !sent) begin
                cmd  = issue_request();
                sent = 1'b1;
              end
            end
            if (ev[EV_D4]) begin
              mode_now = MODE_4;
              if (interactive && !sent) begin
                cmd  = issue_request();
                sent = 1'b1;
              end
            end
            // A bad checksum sends the framer back to hunting for the main header.
            if (byte_sum == 8'h00) begin
              r.status = ST_GOOD;
            end else begin
              r.status   = ST_CSUM_ERR;
              hunt_first = 1'b1;
            end
            r.done    = 1'b1;
            fr_phase  = FR_HEADER;
            frame_len = 8'h00;
            data_seen = 8'h00;
          end
        endcase
      end
      OP_TICK: begin
        // A listening block ignores the timer completely.
        if (interactive) begin
          mode_now = MODE_1;
          if (timed_out) cmd = issue_request();
          timed_out = 1'b1;
        end
      end
      OP_MODE: begin
        idle_byte    = rd;
        wanted_mode  = rq;
        mode_pending = 1'b1;
      end
      default: begin
        clear_link_state();
        cmd = CMD_MODE0;
      end
    endcase
    r.events = ev;
    r.cmd    = cmd;
    r.idle   = (cmd == CMD_SET_IDLE) ? idle_byte : 8'h00;
    r.mode   = mode_now;
    return r;
  endfunction

  // Offers one item on the input stream. Called at a falling edge, returns at a falling edge.
  // Random idle cycles come first; the prediction is made at the edge of the transfer.
  task automatic send_item(input op_t op, input logic [7:0] rx, input logic [2:0] rq,
                           input logic [7:0] rd);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {5'b0, rd, rq, rx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_link_results.push_back(predict_link_item(op, rx, rq, rd));
    items_sent++;
    @(negedge clk);
  endtask

  // A received byte; the unused request fields carry random bits.
  task automatic send_byte(input logic [7:0] b);
    send_item(OP_BYTE, b, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
  endtask

  // Lowers valid and waits until every owed result has come out.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (expected_link_results.size() != 0) @(negedge clk);
  endtask

  // Writes the interactive register while the block is idle.
  task automatic write_interactive(input logic v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    interactive = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Fills frame_buf with one frame of the given shape. The checksum is made good by
  // choosing a free byte where the frame has one, unless the frame is to be corrupted.
  task automatic build_frame(input frame_kind_t kind, input bit corrupt);
    logic [7:0] hdr, tag, end_fix, s;
    bit         has_tag, fixed_end;
    int         flen, slot, fix_at;
    hdr       = ($urandom_range(0, 9) < 8) ? HDR_MAIN :
                ($urandom_range(0, 1) ? HDR_ALT1 : HDR_ALT2);
    has_tag   = 1'b0;
    fixed_end = 1'b0;
    tag       = 8'h00;
    end_fix   = 8'h00;
    case (kind)
      FK_IDLE:   begin flen = TOT_IDLE - 3; fixed_end = 1'b1; end_fix = END_IDLE; end
      FK_SHUTUP: begin flen = TOT_SHORT - 3; fixed_end = 1'b1; end_fix = END_SHUTUP; end
      FK_D0:     flen = TOT_D0 - 3;
      FK_M1REQ: begin
        flen = TOT_M1REQ - 3; has_tag = 1'b1; tag = TAG_MODE1;
        fixed_end = 1'b1; end_fix = END_M1REQ;
      end
      FK_D1:     begin flen = TOT_D1 - 3; has_tag = 1'b1; tag = TAG_MODE1; end
      FK_M3REQ:  begin flen = TOT_M3REQ - 3; has_tag = 1'b1; tag = TAG_MODE3; end
      FK_D3:     begin flen = TOT_D3 - 3; has_tag = 1'b1; tag = TAG_MODE3; end
      FK_M4REQ:  begin flen = TOT_M4REQ - 3; has_tag = 1'b1; tag = TAG_MODE4; end
      FK_D4:     begin flen = TOT_SHORT - 3; has_tag = 1'b1; tag = TAG_MODE4; end
      default: begin
        // Mostly short lengths of up to 15, now and then anything up to the full byte range.
        flen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 15);
      end
    endcase
    frame_buf = {};
    frame_buf.push_back(hdr);
    frame_buf.push_back(8'(flen) + LEN_BIAS);
    for (int i = 0; i < flen; i++) frame_buf.push_back(8'($urandom_range(0, 255)));
    if (has_tag && flen > 0) frame_buf[2] = tag;
    if (fixed_end) begin
      frame_buf.push_back(end_fix);
      slot = (flen >= 1) ? flen + 1 : -1;
    end else begin
      frame_buf.push_back(8'h00);
      slot = flen + 2;
    end
    if (slot >= 0) begin
      s = 8'h00;
      foreach (frame_buf[i]) if (i != slot) s = s + frame_buf[i];
      frame_buf[slot] = 8'h00 - s;
    end
    if (corrupt) begin
      fix_at = (slot >= 0) ? slot : flen + 2;
      frame_buf[fix_at] = frame_buf[fix_at] + 8'($urandom_range(1, 255));
    end
  endtask

  // Random traffic: mostly well-formed frames with random content, some corrupted or cut
  // short, the rest loose bytes, timer ticks, mode requests and restarts.
  task automatic run_random_traffic(input int n_items);
    int target, pick, cut;
    target = items_sent + n_items;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        build_frame(frame_kind_t'($urandom_range(0, 9)), $urandom_range(0, 9) == 0);
        foreach (frame_buf[i]) send_byte(frame_buf[i]);
      end else if (pick < 82) begin
        build_frame(frame_kind_t'($urandom_range(0, 9)), 1'b0);
        cut = $urandom_range(1, frame_buf.size() - 1);
        for (int i = 0; i < cut; i++) send_byte(frame_buf[i]);
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: send_byte(8'($urandom_range(0, 255)));
          4, 5:       send_item(OP_TICK, 8'($urandom_range(0, 255)),
                                3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
          6, 7, 8:    send_item(OP_MODE, 8'($urandom_range(0, 255)),
                                3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
          default:    send_item(OP_RESTART, 8'($urandom_range(0, 255)),
                                3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
        endcase
      end
    end
  endtask

  // Listening only: header search, a timer tick that does nothing, an idle frame that
  // sends nothing, a rejected header and a restart that sends mode 0 anyway.
  task automatic test_listen_only();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_item(OP_TICK, 8'h00, RQ_MODE0, 8'h00);
    send_item(OP_MODE, 8'hFF, RQ_SET_IDLE, 8'hFF);
    send_byte(HDR_MAIN);
    send_byte(LEN_BIAS);
    send_byte(END_IDLE);
    send_byte(8'h07);
    send_item(OP_RESTART, 8'hFF, RQ_MODE0, 8'h00);
  endtask

  // Interactive handlers: the unsupported request, the timeout path, a frame where two
  // handlers want to send and whose checksum fails, an idle frame and a set-idle request.
  task automatic test_interactive_handlers();
    write_interactive(1'b1);
    send_item(OP_MODE, 8'h00, RQ_UNSUP, 8'h00);
    send_item(OP_TICK, 8'hFF, RQ_SET_IDLE, 8'hFF);
    send_item(OP_TICK, 8'h00, RQ_MODE0, 8'h00);
    // Shutup and mode-4 data in one frame, with a bad checksum.
    send_byte(HDR_MAIN);
    send_byte(8'h56);
    send_byte(TAG_MODE4);
    send_byte(END_SHUTUP);
    // Hunting again, so an alternate header is not accepted yet.
    send_byte(HDR_ALT1);
    send_byte(HDR_MAIN);
    send_byte(LEN_BIAS);
    send_byte(END_IDLE);
    send_item(OP_MODE, 8'h00, RQ_SET_IDLE, 8'hA5);
    // Mode-4 data frame under an alternate header; its handler sends set idle.
    send_byte(HDR_ALT2);
    send_byte(8'h56);
    send_byte(TAG_MODE4);
    send_byte(8'h9C);
  endtask

  // A no-op transfer between two back-to-back register writes keeps valid from being
  // dropped and raised in one step.
  task automatic write_interactive_settle();
    send_item(OP_TICK, 8'h00, RQ_MODE0, 8'h00);
  endtask

  // Random traffic in several idling phases, switching the register between them.
  task automatic test_random_phases();
    send_idle_pct = 0;
    stall_pct <= 0;
    run_random_traffic(140);
    write_interactive(1'b0);
    send_idle_pct = 60;
    stall_pct <= 0;
    run_random_traffic(140);
    write_interactive(1'b1);
    send_idle_pct = 0;
    stall_pct <= 60;
    run_random_traffic(140);
    write_interactive(1'b0);
    write_interactive_settle();
    write_interactive(1'b1);
    send_idle_pct = 26;
    stall_pct <= 26;
    run_random_traffic(140);
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering items,
  // so the block fills up and stops taking input.
  task automatic test_backpressure();
    drain_results();
    send_idle_pct = 0;
    stall_pct <= 0;
    hold_seq  <= hold_seq + 1;
    for (int i = 0; i < 24; i++) begin
      if (i % 3 == 0) send_item(OP_TICK, 8'h00, RQ_MODE1, 8'h00);
      else send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Receiver side: ready changes at the falling edge, with random stalls or a counted
  // hold-off when the backpressure test asks for one.
  initial begin : result_sink
    int hold_seen, hold_left;
    hold_seen  = 0;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Every result transfer is compared field by field with the oldest expectation.
  always @(posedge clk) begin : result_check
    link_result_t got, want;
    if (out_tvalid === 1'b1 && out_tready) begin
      got.status = out_tdata[2:0];
      got.done   = out_tlast;
      got.events = out_tdata[11:3];
      got.cmd    = out_tdata[15:12];
      got.idle   = out_tdata[23:16];
      got.mode   = out_tdata[26:24];
      if (expected_link_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("error: result with nothing expected: status=%0d done=%0d ev=%03h",
                   got.status, got.done, got.events);
        end
      end else begin
        want = expected_link_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("error: expected status=%0d done=%0d ev=%03h cmd=%0d idle=%02h mode=%0d",
                     want.status, want.done, want.events, want.cmd, want.idle, want.mode);
            $display("          actual status=%0d done=%0d ev=%03h cmd=%0d idle=%02h mode=%0d",
                     got.status, got.done, got.events, got.cmd, got.idle, got.mode);
          end
        end
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = OP_BYTE;
    cfg_valid = 1'b0;
    cfg_data  = 1'b0;
    clear_link_state();
    timed_out   = 1'b0;
    interactive = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_listen_only();
    test_interactive_handlers();
    test_random_phases();
    test_backpressure();

    // Let the last results out, then allow a few cycles for anything stray.
    drain_results();
    repeat (8) @(negedge clk);
    if (expected_link_results.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
